// ===== src/pcq_pkg.sv =====
// ----------------------------------------------------------------------------
// pcq_pkg: shared constants and helpers of the palette color quantizer
// Holds the default palette, luma weights, color cube level tables and the
// small channel arithmetic used by the pipeline.
// ----------------------------------------------------------------------------
package pcq_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int RED_LEVELS      = 6;
  localparam int GREEN_LEVELS    = 8;
  localparam int BLUE_LEVELS     = 5;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);

  localparam logic [1:0] DEPTH_ONE  = 2'd0;
  localparam logic [1:0] DEPTH_FOUR = 2'd1;
  localparam logic [1:0] DEPTH_EIGHT = 2'd2;
  localparam logic [1:0] DEPTH_SPARE = 2'd3;

  localparam logic [1:0] MODE_EXPAND = 2'd0;
  localparam logic [1:0] MODE_REDUCE = 2'd1;
  localparam logic [1:0] MODE_WRITE  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic       REG_DEPTH   = 1'b0;
  localparam logic       REG_ONE_BIT = 1'b1;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  // Reciprocals for division of the cube offset by 5 and of that by 8 by 6.
  localparam logic [23:0] RECIP_5 = 24'd13421773;
  localparam int          SHIFT_5 = 26;
  localparam logic [19:0] RECIP_6 = 20'd699051;
  localparam int          SHIFT_6 = 22;

  localparam logic [23:0] DEFAULT_PALETTE [PALETTE_ENTRIES] = '{
    24'hFFFFFF, 24'hFFCC33, 24'hCC66CC, 24'h6699FF,
    24'hFFFF33, 24'h33CC33, 24'hFF6699, 24'h333333,
    24'hCCCCCC, 24'h336699, 24'h9933CC, 24'h333399,
    24'h663300, 24'h336600, 24'hFF3333, 24'h000000
  };

  localparam logic [7:0] RED_TAB   [8] = '{8'd0, 8'd51, 8'd102, 8'd153,
                                           8'd204, 8'd255, 8'd0, 8'd0};
  localparam logic [7:0] GREEN_TAB [8] = '{8'd0, 8'd36, 8'd73, 8'd109,
                                           8'd146, 8'd182, 8'd219, 8'd255};
  localparam logic [7:0] BLUE_TAB  [8] = '{8'd0, 8'd64, 8'd128, 8'd191,
                                           8'd255, 8'd0, 8'd0, 8'd0};

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Nearest cube level of one channel: counts thresholds 510*L that the
  // scaled value reaches, which equals (c*2*(N-1)+255)/510.
  function automatic logic [2:0] chan_level(input logic [7:0] c, input int levels);
    logic [12:0] t;
    logic [2:0]  n;
    t = 13'(c) * 13'(2 * (levels - 1)) + 13'd255;
    n = 3'd0;
    for (int l = 1; l < 8; l++) begin
      if (l < levels && t >= 13'(510 * l)) n = n + 3'd1;
    end
    return n;
  endfunction

endpackage

// ===== src/palette_color_quantizer.sv =====
// A word accepted on in_* passes the stage 1 to 4 registers and the output register before it leaves on out_*.
// Throughput: one word per cycle; every stage has its own valid bit and
// holds only while the stage after it is full and stalled.
// Palette writes take effect at acceptance, so later words see them.
// Reset (rst_n low, synchronous) empties the pipeline, restores the default
// palette, four-bit depth and a white one-bit color.
// ----------------------------------------------------------------------------
// palette_color_quantizer
// Converts between 24-bit RGB and palette indices with a five-stage pipeline
// of distance computation and a registered minimum tree.
// ----------------------------------------------------------------------------
module palette_color_quantizer
  import pcq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [23:0] in_value_in,
  input  logic        in_value_is_index,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_result_value,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int NC = PALETTE_ENTRIES + 1;  // palette entries plus the cube color

  // Configuration registers. Depth code 3 is stored as eight-bit.
  logic [1:0]  depth_r;
  logic [23:0] one_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= DEPTH_FOUR;
      one_bit_r <= 24'hFFFFFF;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_DEPTH) begin
        depth_r <= (cfg_wdata[1:0] == DEPTH_SPARE) ? DEPTH_EIGHT : cfg_wdata[1:0];
      end else begin
        one_bit_r <= cfg_wdata;
      end
    end
  end

  // Stage enables: a stage loads when it is empty or the next one moves.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  logic accept;
  assign accept = in_valid && in_ready;

  // Palette store, written at acceptance so that word order is kept.
  logic [23:0] pal_r [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) pal_r[i] <= DEFAULT_PALETTE[i];
    end else if (accept && in_mode == MODE_WRITE && depth_r != DEPTH_ONE) begin
      if (in_entry_index > 8'(PALETTE_ENTRIES - 1)) begin
        pal_r[PALETTE_ENTRIES - 1] <= in_value_in;
      end else begin
        pal_r[in_entry_index[IDX_W-1:0]] <= in_value_in;
      end
    end
  end

  // Stage 0: channel differences against every entry and the nearest cube
  // color, the palette lookup for expansion and the first cube division.
  logic [7:0]  d0 [NC][3];
  logic [2:0]  lvl_r0, lvl_g0, lvl_b0;
  logic [7:0]  cube_idx0;
  logic [23:0] cube_col0;
  logic [IDX_W-1:0] pal_addr0;
  logic [23:0] k0;
  logic        has_res0;

  always_comb begin
    lvl_r0 = chan_level(in_value_in[23:16], RED_LEVELS);
    lvl_g0 = chan_level(in_value_in[15:8], GREEN_LEVELS);
    lvl_b0 = chan_level(in_value_in[7:0], BLUE_LEVELS);
    cube_idx0 = 8'(PALETTE_ENTRIES) + 8'(lvl_r0) * 8'(GREEN_LEVELS * BLUE_LEVELS)
              + 8'(lvl_g0) * 8'(BLUE_LEVELS) + 8'(lvl_b0);
    cube_col0 = {RED_TAB[lvl_r0], GREEN_TAB[lvl_g0], BLUE_TAB[lvl_b0]};
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      d0[i][0] = abs_diff(in_value_in[23:16], pal_r[i][23:16]);
      d0[i][1] = abs_diff(in_value_in[15:8], pal_r[i][15:8]);
      d0[i][2] = abs_diff(in_value_in[7:0], pal_r[i][7:0]);
    end
    d0[NC-1][0] = abs_diff(in_value_in[23:16], cube_col0[23:16]);
    d0[NC-1][1] = abs_diff(in_value_in[15:8], cube_col0[15:8]);
    d0[NC-1][2] = abs_diff(in_value_in[7:0], cube_col0[7:0]);
    if (depth_r == DEPTH_FOUR && in_value_in > 24'(PALETTE_ENTRIES - 1)) begin
      pal_addr0 = IDX_W'(PALETTE_ENTRIES - 1);
    end else begin
      pal_addr0 = in_value_in[IDX_W-1:0];
    end
    k0 = in_value_in - 24'(PALETTE_ENTRIES);
    has_res0 = (in_mode == MODE_EXPAND) || (in_mode == MODE_REDUCE);
  end

  // Flags that ride along to the end of the pipe.
  typedef struct packed {
    logic        expand;    // index to color, else color to index
    logic        is_index;
    logic        v_zero;
    logic        v_small;   // value below the palette size
    logic [IDX_W-1:0] v_low;
    logic [23:0] pal_col;
    logic [7:0]  cube_idx;
  } side_t;

  side_t side0, side1_r, side2_r, side3_r, side4_r;
  assign side0 = '{expand:   (in_mode == MODE_EXPAND),
                   is_index: in_value_is_index,
                   v_zero:   (in_value_in == 24'd0),
                   v_small:  (in_value_in < 24'(PALETTE_ENTRIES)),
                   v_low:    in_value_in[IDX_W-1:0],
                   pal_col:  pal_r[pal_addr0],
                   cube_idx: cube_idx0};

  // Stage 1 registers.
  logic [7:0]  d1_r [NC][3];
  logic [47:0] p5_1_r;
  logic [23:0] k1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= accept && has_res0;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r    <= d0;
      p5_1_r  <= 48'(k0) * 48'(RECIP_5);
      k1_r    <= k0;
      side1_r <= side0;
    end
  end

  // Stage 1 -> 2: squares, blue and green cube levels, second division.
  logic [21:0] q5_1;
  logic [18:0] q40_1;
  logic [23:0] rem5_1;
  assign q5_1   = p5_1_r[SHIFT_5 +: 22];
  assign q40_1  = q5_1[21:3];
  assign rem5_1 = k1_r - 24'(q5_1) * 24'd5;

  logic [15:0] sq2_r [NC][3];
  logic [38:0] p6_2_r;
  logic [18:0] q40_2_r;
  logic [2:0]  lg2_r, lb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < NC; i++) begin
        for (int c = 0; c < 3; c++) sq2_r[i][c] <= 16'(d1_r[i][c]) * 16'(d1_r[i][c]);
      end
      p6_2_r  <= 39'(q40_1) * 39'(RECIP_6);
      q40_2_r <= q40_1;
      lg2_r   <= q5_1[2:0];
      lb2_r   <= rem5_1[2:0];
      side2_r <= side1_r;
    end
  end

  // Stage 2 -> 3: weighted distances and the expanded cube color.
  logic [16:0] q6_2;
  logic [18:0] rem6_2;
  assign q6_2   = p6_2_r[SHIFT_6 +: 17];
  assign rem6_2 = q40_2_r - 19'(q6_2) * 19'd6;

  logic [31:0] dist3_r [NC];
  logic [23:0] cube_exp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < NC; i++) begin
        dist3_r[i] <= 32'(sq2_r[i][0]) * 32'(W_RED) + 32'(sq2_r[i][1]) * 32'(W_GREEN)
                    + 32'(sq2_r[i][2]) * 32'(W_BLUE);
      end
      cube_exp3_r <= {RED_TAB[rem6_2[2:0]], GREEN_TAB[lg2_r], BLUE_TAB[lb2_r]};
      side3_r     <= side2_r;
    end
  end

  // Stage 3 -> 4: two levels of the minimum tree, sixteen down to four.
  // Ties keep the lower index since only a strictly smaller distance wins.
  logic [31:0] t4_d [4];
  logic [IDX_W-1:0] t4_i [4];

  always_comb begin
    logic [31:0] ad [8];
    logic [IDX_W-1:0] ai [8];
    for (int j = 0; j < 8; j++) begin
      if (dist3_r[2*j+1] < dist3_r[2*j]) begin
        ad[j] = dist3_r[2*j+1];
        ai[j] = IDX_W'(2*j+1);
      end else begin
        ad[j] = dist3_r[2*j];
        ai[j] = IDX_W'(2*j);
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (ad[2*j+1] < ad[2*j]) begin
        t4_d[j] = ad[2*j+1];
        t4_i[j] = ai[2*j+1];
      end else begin
        t4_d[j] = ad[2*j];
        t4_i[j] = ai[2*j];
      end
    end
  end

  logic [31:0] d4_r [4];
  logic [IDX_W-1:0] i4_r [4];
  logic [31:0] dcube4_r;
  logic [23:0] cube_exp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      d4_r        <= t4_d;
      i4_r        <= t4_i;
      dcube4_r    <= dist3_r[NC-1];
      cube_exp4_r <= cube_exp3_r;
      side4_r     <= side3_r;
    end
  end

  // Stage 4 -> 5: last two tree levels, cube comparison and result select.
  logic [23:0] res4;

  always_comb begin
    logic [31:0] bd0, bd1, bd;
    logic [IDX_W-1:0] bi0, bi1, bi;
    bd0 = (d4_r[1] < d4_r[0]) ? d4_r[1] : d4_r[0];
    bi0 = (d4_r[1] < d4_r[0]) ? i4_r[1] : i4_r[0];
    bd1 = (d4_r[3] < d4_r[2]) ? d4_r[3] : d4_r[2];
    bi1 = (d4_r[3] < d4_r[2]) ? i4_r[3] : i4_r[2];
    bd  = (bd1 < bd0) ? bd1 : bd0;
    bi  = (bd1 < bd0) ? bi1 : bi0;
    if (side4_r.expand) begin
      if (depth_r == DEPTH_ONE) begin
        res4 = side4_r.v_zero ? 24'd0 : one_bit_r;
      end else if (depth_r == DEPTH_FOUR || side4_r.v_small) begin
        res4 = side4_r.pal_col;
      end else begin
        res4 = cube_exp4_r;
      end
    end else begin
      if (depth_r == DEPTH_ONE) begin
        res4 = side4_r.v_zero ? 24'd0 : 24'd1;
      end else if (side4_r.is_index) begin
        res4 = 24'(side4_r.v_low);
      end else if (depth_r == DEPTH_FOUR || !(dcube4_r < bd)) begin
        res4 = 24'(bi);
      end else begin
        res4 = 24'(side4_r.cube_idx);
      end
    end
  end

  // Output register.
  logic [23:0] res5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      res5_r <= res4;
    end
  end

  assign out_valid        = v5_r;
  assign out_result_value = res5_r;

  // A full stage that cannot move keeps its word.
  assert property (@(posedge clk) disable iff (!rst_n) (v4_r && !en5) |=> v4_r)
    else $error("stage 4 word lost during stall");
  // Input is refused only when the first stage is full and blocked.
  assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> (v1_r && !en2))
    else $error("input refused with room in stage 1");
  // The spare depth code is never stored.
  assert property (@(posedge clk) disable iff (!rst_n) depth_r != DEPTH_SPARE)
    else $error("spare depth code stored");
  // An output word that waits stays valid.
  assert property (@(posedge clk) disable iff (!rst_n) (v5_r && !out_ready) |=> v5_r)
    else $error("waiting output word dropped");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for palette_color_quantizer
// Drives expand, reduce and palette-write words under all depth settings,
// predicts each result from a local model of the palette and the color cube,
// and checks results in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import pcq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [23:0] in_value_in;
  logic        in_value_is_index;
  logic [7:0]  in_entry_index;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_result_value;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  palette_color_quantizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_value_in(in_value_in), .in_value_is_index(in_value_is_index),
    .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Constant weights of the color distance, Q0.16 luma.
  localparam logic [63:0] LUMA_R = 64'd13933;
  localparam logic [63:0] LUMA_G = 64'd46871;
  localparam logic [63:0] LUMA_B = 64'd4732;
  localparam int STALL_LIMIT = 20000;

  // Model state: depth setting, one-bit color and the sixteen stored colors.
  logic [1:0]  model_depth;
  logic [23:0] model_fg;
  logic [23:0] model_pal [PALETTE_ENTRIES];

  logic [23:0] expected_colors [$];
  int  errors;
  int  words_sent;
  int  results_seen;
  int  idle_cycles;
  bit  hold_off;    // long receiver stall requested by the backpressure test
  bit  rx_active;   // random receiver stalls enabled

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [63:0] color_dist(logic [23:0] a, logic [23:0] b);
    logic [63:0] dr, dg, db;
    dr = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    dg = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
    db = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
    return LUMA_R * dr * dr + LUMA_G * dg * dg + LUMA_B * db * db;
  endfunction

  // Color of a cube index; wraps through the level formula for large values.
  function automatic logic [23:0] cube_rgb(logic [23:0] v);
    logic [31:0] k, lr, lg, lb, r, g, b;
    k  = 32'(v) - 32'd16;
    lb = k % 5;
    lg = (k / 5) % 8;
    lr = (k / 40) % 6;
    r  = (lr * 510 + 5) / 10;
    g  = (lg * 510 + 7) / 14;
    b  = (lb * 510 + 4) / 8;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [23:0] expand_index(logic [23:0] v);
    if (model_depth == DEPTH_ONE) return (v == 0) ? 24'd0 : model_fg;
    if (model_depth == DEPTH_FOUR) return model_pal[(v > 15) ? 15 : v[3:0]];
    if (v < 16) return model_pal[v[3:0]];
    return cube_rgb(v);
  endfunction

  function automatic logic [23:0] quantize_color(logic [23:0] v, logic is_idx);
    int best;
    logic [63:0] bd, d;
    logic [31:0] r, g, b;
    logic [23:0] cube;
    if (model_depth == DEPTH_ONE) return (v == 0) ? 24'd0 : 24'd1;
    if (is_idx) return {20'd0, v[3:0]};
    best = 0;
    bd = color_dist(v, model_pal[0]);
    for (int i = 1; i < PALETTE_ENTRIES; i++) begin
      d = color_dist(v, model_pal[i]);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    if (model_depth == DEPTH_FOUR) return 24'(best);
    r = (32'(v[23:16]) * 10 + 255) / 510;
    g = (32'(v[15:8]) * 14 + 255) / 510;
    b = (32'(v[7:0]) * 8 + 255) / 510;
    cube = 24'(16 + r * 40 + g * 5 + b);
    if (color_dist(cube_rgb(cube), v) < bd) return cube;
    return 24'(best);
  endfunction

  // Model of one accepted word: pushes its result or updates the palette.
  function automatic void predict_word(logic [1:0] m, logic [23:0] v, logic ix,
                                       logic [7:0] e);
    if (m == MODE_EXPAND) expected_colors.push_back(expand_index(v));
    else if (m == MODE_REDUCE) expected_colors.push_back(quantize_color(v, ix));
    else if (m == MODE_WRITE && model_depth != DEPTH_ONE)
      model_pal[(e > 15) ? 15 : e[3:0]] = v;
  endfunction

  // An idle gap drops valid first; without a gap the next word follows directly.
  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return;
    in_valid <= 1'b0;
    repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge clk);
  endtask

  // Offers one word and waits until it is accepted.
  task automatic send_word(logic [1:0] m, logic [23:0] v, logic ix, logic [7:0] e,
                           bit gaps = 1);
    if (gaps) random_gap();
    in_valid          <= 1'b1;
    in_mode           <= m;
    in_value_in       <= v;
    in_value_is_index <= ix;
    in_entry_index    <= e;
    do @(posedge clk); while (!in_ready);
    predict_word(m, v, ix, e);
    words_sent++;
  endtask

  // Waits for every result, then idles before returning.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] data);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_DEPTH) model_depth = (data[1:0] == DEPTH_SPARE) ? DEPTH_EIGHT
                                                                   : data[1:0];
    else model_fg = data;
  endtask

  // Colors near palette entries and cube points make the tie-breaks likely.
  function automatic logic [23:0] pick_color();
    int r;
    logic [23:0] c;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      c = model_pal[$urandom_range(0, 15)];
      if ($urandom_range(0, 1)) c = c ^ 24'($urandom_range(0, 7)) << (8 * $urandom_range(0, 2));
      return c;
    end
    if (r < 5) return cube_rgb(24'($urandom_range(16, 255)));
    return 24'($urandom);
  endfunction

  task automatic random_word();
    int r;
    logic [23:0] v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: v = 24'($urandom_range(0, 15));
        1: v = 24'($urandom_range(16, 255));
        2: v = 24'd0;
        default: v = 24'($urandom);
      endcase
      send_word(MODE_EXPAND, v, 1'($urandom), 8'($urandom));
    end else if (r < 85) begin
      if ($urandom_range(0, 4) == 0) send_word(MODE_REDUCE, 24'($urandom), 1'b1, 8'($urandom));
      else send_word(MODE_REDUCE, pick_color(), 1'b0, 8'($urandom));
    end else if (r < 95) begin
      send_word(MODE_WRITE, pick_color(), 1'($urandom), 8'($urandom));
    end else begin
      send_word(MODE_SPARE, 24'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  // Directed words: field extremes, every mode, one-bit writes ignored,
  // spare depth code, unused mode, clamped write index and oversized index.
  task automatic test_directed();
    send_word(MODE_EXPAND, 24'd0, 1'b0, 8'd0);
    send_word(MODE_EXPAND, 24'hFFFFFF, 1'b1, 8'hFF);
    send_word(MODE_REDUCE, 24'h000000, 1'b0, 8'd0);
    send_word(MODE_REDUCE, 24'hFFFFFF, 1'b0, 8'd0);
    send_word(MODE_REDUCE, 24'hFFFFFF, 1'b1, 8'd0);
    send_word(MODE_WRITE, 24'h123456, 1'b0, 8'hFF);
    send_word(MODE_EXPAND, 24'd15, 1'b0, 8'd0);
    send_word(MODE_SPARE, 24'hABCDEF, 1'b1, 8'd3);
    write_reg(REG_DEPTH, 24'(DEPTH_EIGHT));
    send_word(MODE_EXPAND, 24'd16, 1'b0, 8'd0);
    send_word(MODE_EXPAND, 24'd255, 1'b0, 8'd0);
    send_word(MODE_EXPAND, 24'd256, 1'b0, 8'd0);
    send_word(MODE_EXPAND, 24'hFFFFFF, 1'b0, 8'd0);
    send_word(MODE_REDUCE, 24'h808080, 1'b0, 8'd0);
    send_word(MODE_REDUCE, 24'h33CC33, 1'b0, 8'd0);
    send_word(MODE_REDUCE, 24'h0000FF, 1'b0, 8'd0);
    write_reg(REG_DEPTH, 24'(DEPTH_SPARE));
    send_word(MODE_REDUCE, 24'hFF0000, 1'b0, 8'd0);
    write_reg(REG_DEPTH, 24'(DEPTH_ONE));
    write_reg(REG_ONE_BIT, 24'h000000);
    send_word(MODE_EXPAND, 24'd1, 1'b0, 8'd0);
    write_reg(REG_ONE_BIT, 24'hA5C35A);
    send_word(MODE_EXPAND, 24'hFFFFFF, 1'b0, 8'd0);
    send_word(MODE_WRITE, 24'h000000, 1'b0, 8'd0);
    send_word(MODE_REDUCE, 24'd0, 1'b1, 8'd0);
    send_word(MODE_REDUCE, 24'd7, 1'b1, 8'd0);
    write_reg(REG_DEPTH, 24'(DEPTH_FOUR));
    send_word(MODE_EXPAND, 24'd0, 1'b0, 8'd0);
  endtask

  // Random words under each depth setting in turn, with a new one-bit color.
  task automatic test_random(int count);
    logic [1:0] depths [4] = '{DEPTH_FOUR, DEPTH_EIGHT, DEPTH_ONE, DEPTH_SPARE};
    foreach (depths[p]) begin
      write_reg(REG_DEPTH, 24'(depths[p]));
      write_reg(REG_ONE_BIT, (p == 0) ? 24'hFFFFFF : 24'($urandom));
      repeat (count / 4) random_word();
    end
  endtask

  // The receiver holds off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    write_reg(REG_DEPTH, 24'(DEPTH_EIGHT));
    hold_off = 1'b1;
    repeat (30) send_word(MODE_REDUCE, pick_color(), 1'b0, 8'd0, 0);
    hold_off = 1'b0;
    repeat (40) send_word(MODE_EXPAND, 24'($urandom_range(0, 300)), 1'b0, 8'd0, 0);
  endtask

  // Receiver: random stalls, with a long counted hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        stall = 0;
        while (stall < 60) begin
          @(posedge clk);
          stall++;
        end
        out_ready <= 1'b1;
      end else if (rx_active && $urandom_range(0, 99) < 15) begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: every accepted word must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_colors.size() == 0) begin
        $error("unexpected result_value %h", out_result_value);
        errors++;
      end else begin
        logic [23:0] want;
        want = expected_colors.pop_front();
        if (out_result_value !== want) begin
          $error("result_value expected %h actual %h", want, out_result_value);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_colors.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_EXPAND;
    in_value_in = '0;
    in_value_is_index = 1'b0;
    in_entry_index = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_DEPTH;
    cfg_wdata = '0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    rx_active = 1'b0;
    model_depth = DEPTH_FOUR;
    model_fg = 24'hFFFFFF;
    foreach (model_pal[i]) model_pal[i] = DEFAULT_PALETTE[i];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    rx_active = 1'b1;
    test_random(1160);
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d words and %0d results over all depths, writes and stalls.",
             words_sent, results_seen);
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_colors.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
